[hdl/bthp_pkg.sv]
package bthp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_UUID       = 3'd2,
    ST_ENCRYPTED  = 3'd3,
    ST_VERSION    = 3'd4,
    ST_NO_READING = 3'd5
  } status_e;

  typedef struct packed {
    status_e            status;
    logic signed [19:0] temperature_centi;
    logic               temperature_valid;
    logic [9:0]         humidity_pct;
    logic               humidity_valid;
    logic [7:0]         battery_level;
    logic               battery_valid;
  } out_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ID     = 2'd1,
    PH_DATA   = 2'd2,
    PH_STOP   = 2'd3
  } phase_e;

  localparam logic [7:0] ID_PACKET     = 8'h00;
  localparam logic [7:0] ID_BATTERY    = 8'h01;
  localparam logic [7:0] ID_TEMP_CENTI = 8'h02;
  localparam logic [7:0] ID_HUM_CENTI  = 8'h03;
  localparam logic [7:0] ID_HUM_PCT    = 8'h2E;
  localparam logic [7:0] ID_TEMP_DECI  = 8'h45;

  localparam logic [15:0] SERVICE_UUID = 16'hFCD2;
  localparam logic [2:0]  HDR_VERSION  = 3'd2;
  localparam logic [2:0]  MIN_LEN      = 3'd6;
  localparam logic [2:0]  COUNT_MAX    = 3'd7;

  // floor(x / 100) == (x * 83887) >> 23 for every 16-bit x
  localparam logic [16:0] HUM_RECIP = 17'd83887;
  localparam int          HUM_SHIFT = 23;

  localparam int FLAG_TEMP = 0;
  localparam int FLAG_HUM  = 1;
  localparam int FLAG_BATT = 2;

endpackage

[hdl/bthp_parse.sv]
module bthp_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           byte_acc_i,
  input  bthp_pkg::in_t  byte_i,
  output logic           res_valid_o,
  output bthp_pkg::out_t res_o
);
  import bthp_pkg::*;

  phase_e             phase_q, phase_d;
  logic [2:0]         count_q, count_d;
  logic [7:0]         uuid_low_q, uuid_low_d;
  logic [7:0]         code_q, code_d;
  logic [1:0]         left_q, left_d;
  logic [7:0]         first_q, first_d;
  status_e            err_q, err_d;
  logic signed [19:0] temp_q, temp_d;
  logic [9:0]         hum_q, hum_d;
  logic [7:0]         batt_q, batt_d;
  logic [2:0]         found_q, found_d;

  logic [7:0]         b;
  logic [15:0]        word;
  logic signed [19:0] word_sx;
  logic signed [19:0] temp_deci;
  logic [32:0]        hum_prod;
  logic               len_one, len_two;
  status_e            status;
  logic               show;

  assign b         = byte_i.data_byte;
  assign word      = {b, first_q};
  assign word_sx   = {{4{word[15]}}, word};
  assign temp_deci = (word_sx <<< 3) + (word_sx <<< 1);
  assign hum_prod  = {17'd0, word} * {16'd0, HUM_RECIP};

  always_comb begin
    len_one = 1'b0;
    len_two = 1'b0;
    unique case (b) inside
      ID_PACKET, ID_BATTERY, ID_HUM_PCT:        len_one = 1'b1;
      ID_TEMP_CENTI, ID_HUM_CENTI, ID_TEMP_DECI: len_two = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_HEADER: begin
        if (count_q != 3'd0 && count_q != 3'd1) begin
          phase_d = (err_d != ST_OK) ? PH_STOP : PH_ID;
        end
      end
      PH_ID:   phase_d = (len_one || len_two) ? PH_DATA : PH_STOP;
      PH_DATA: if (left_q != 2'd2) phase_d = PH_ID;
      PH_STOP: ;
      default: ;
    endcase
  end

  always_comb begin
    uuid_low_d = uuid_low_q;
    code_d     = code_q;
    left_d     = left_q;
    first_d    = first_q;
    err_d      = err_q;
    temp_d     = temp_q;
    hum_d      = hum_q;
    batt_d     = batt_q;
    found_d    = found_q;
    unique case (phase_q)
      PH_HEADER: begin
        if (count_q == 3'd0) begin
          uuid_low_d = b;
        end else if (count_q == 3'd1) begin
          if ({b, uuid_low_q} != SERVICE_UUID) err_d = ST_UUID;
        end else if (err_q == ST_OK) begin
          if (b[0]) err_d = ST_ENCRYPTED;
          else if (b[7:5] != HDR_VERSION) err_d = ST_VERSION;
        end
      end
      PH_ID: begin
        code_d = b;
        if (len_one) left_d = 2'd1;
        else if (len_two) left_d = 2'd2;
      end
      PH_DATA: begin
        if (left_q == 2'd2) begin
          first_d = b;
          left_d  = 2'd1;
        end else begin
          left_d = 2'd0;
          case (code_q)
            ID_BATTERY: begin
              batt_d             = b;
              found_d[FLAG_BATT] = 1'b1;
            end
            ID_HUM_PCT: begin
              hum_d             = {2'd0, b};
              found_d[FLAG_HUM] = 1'b1;
            end
            ID_HUM_CENTI: begin
              hum_d             = hum_prod[HUM_SHIFT +: 10];
              found_d[FLAG_HUM] = 1'b1;
            end
            ID_TEMP_CENTI: begin
              temp_d             = word_sx;
              found_d[FLAG_TEMP] = 1'b1;
            end
            ID_TEMP_DECI: begin
              temp_d             = temp_deci;
              found_d[FLAG_TEMP] = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    count_d = (count_q == COUNT_MAX) ? count_q : count_q + 3'd1;
  end

  always_comb begin
    if (count_d < MIN_LEN) status = ST_SHORT;
    else if (err_d != ST_OK) status = err_d;
    else if (found_d[FLAG_TEMP] || found_d[FLAG_HUM]) status = ST_OK;
    else status = ST_NO_READING;
    show = (status == ST_OK) || (status == ST_NO_READING);

    res_o.status            = status;
    res_o.temperature_valid = show & found_d[FLAG_TEMP];
    res_o.temperature_centi = res_o.temperature_valid ? temp_d : '0;
    res_o.humidity_valid    = show & found_d[FLAG_HUM];
    res_o.humidity_pct      = res_o.humidity_valid ? hum_d : '0;
    res_o.battery_valid     = show & found_d[FLAG_BATT];
    res_o.battery_level     = res_o.battery_valid ? batt_d : '0;
  end

  assign res_valid_o = byte_acc_i & byte_i.last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      count_q    <= '0;
      uuid_low_q <= '0;
      code_q     <= '0;
      left_q     <= '0;
      first_q    <= '0;
      err_q      <= ST_OK;
      temp_q     <= '0;
      hum_q      <= '0;
      batt_q     <= '0;
      found_q    <= '0;
    end else if (byte_acc_i) begin
      if (byte_i.last_byte) begin
        phase_q    <= PH_HEADER;
        count_q    <= '0;
        uuid_low_q <= '0;
        code_q     <= '0;
        left_q     <= '0;
        first_q    <= '0;
        err_q      <= ST_OK;
        temp_q     <= '0;
        hum_q      <= '0;
        batt_q     <= '0;
        found_q    <= '0;
      end else begin
        phase_q    <= phase_d;
        count_q    <= count_d;
        uuid_low_q <= uuid_low_d;
        code_q     <= code_d;
        left_q     <= left_d;
        first_q    <= first_d;
        err_q      <= err_d;
        temp_q     <= temp_d;
        hum_q      <= hum_d;
        batt_q     <= batt_d;
        found_q    <= found_d;
      end
    end
  end

endmodule

[hdl/bthome_v2_service_data_parser.sv]
// Service-data frame parser for BTHome v2 advertisements.
// Input channel: one frame byte per item (in_data_i.data_byte), with
// in_data_i.last_byte set on the final byte of the frame. An item is taken
// at a clock edge where in_valid_i is high and in_stall_o is low.
// Output channel: one item per frame, emitted after its last byte, carrying
// status, temperature, humidity and battery readings with valid flags.
// Taken at an edge where out_valid_o is high and out_stall_i is low.
// Throughput: one byte per cycle while in_stall_o is low; each byte updates the
// parse state as it is taken (one 16x17 multiply for the humidity divide by 100).
// The result is formed combinationally from the last byte and registered in the
// result register, or in the skid entry while that register is still held.
// A result register plus one skid entry sit on the output side, so bytes
// keep flowing while a result waits; in_stall_o rises only when both
// entries are full, and falls once the receiver takes a result.
// Reset (rst_ni low, asynchronous) clears the parse state and empties the
// output entries; the first byte after reset starts a new frame.
module bthome_v2_service_data_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bthp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bthp_pkg::out_t out_data_o
);
  import bthp_pkg::*;

  logic in_acc;
  logic res_valid;
  out_t res;
  logic out_take;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  out_t out_q, out_d;
  out_t skid_q, skid_d;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  bthp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_acc_i  (in_acc),
    .byte_i      (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[tb/tb_bthome_v2_service_data_parser.sv]
`timescale 1ns / 100ps

module tb_bthome_v2_service_data_parser;
  import bthp_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int STIM_BYTES     = 850;
  localparam int TAIL_BYTES     = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic byte_valid = 1'b0;
  logic byte_stall;
  in_t  byte_item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result_item;

  in_t        pending_bytes[$];
  out_t       expected_readings[$];
  logic [7:0] frame_buf[$];

  // parser state mirror
  logic [2:0]         fr_count;
  logic [7:0]         uuid_lo;
  phase_e             phase;
  logic [7:0]         obj_id;
  logic [1:0]         bytes_due;
  logic [7:0]         low_byte;
  status_e            hdr_err;
  logic signed [19:0] temp_acc;
  logic [9:0]         hum_acc;
  logic [7:0]         batt_acc;
  logic [2:0]         seen;

  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  logic held_once = 1'b0;
  logic quiet_tail = 1'b0;
  int   idle_cycles = 0;
  int   fail_count = 0;
  int   bytes_taken = 0;
  int   frames_closed = 0;
  int   results_seen = 0;
  int   ok_count = 0;
  int   none_count = 0;
  int   reject_count = 0;

  bthome_v2_service_data_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_valid),
    .in_stall_o (byte_stall),
    .in_data_i  (byte_item),
    .out_valid_o(result_valid),
    .out_stall_i(result_stall),
    .out_data_o (result_item)
  );

  always #5 clk_i = ~clk_i;

  task automatic restart_frame();
    fr_count  = '0;
    uuid_lo   = '0;
    phase     = PH_HEADER;
    obj_id    = '0;
    bytes_due = '0;
    low_byte  = '0;
    hdr_err   = ST_OK;
    temp_acc  = '0;
    hum_acc   = '0;
    batt_acc  = '0;
    seen      = '0;
  endtask

  task automatic store_object(input logic [7:0] b);
    logic [15:0] word;
    int          t16;
    word = {b, low_byte};
    t16  = int'($signed(word));
    case (obj_id)
      ID_BATTERY: begin
        batt_acc = b;
        seen[FLAG_BATT] = 1'b1;
      end
      ID_HUM_PCT: begin
        hum_acc = {2'b00, b};
        seen[FLAG_HUM] = 1'b1;
      end
      ID_HUM_CENTI: begin
        hum_acc = 10'(word / 16'd100);
        seen[FLAG_HUM] = 1'b1;
      end
      ID_TEMP_CENTI: begin
        temp_acc = 20'(t16);
        seen[FLAG_TEMP] = 1'b1;
      end
      ID_TEMP_DECI: begin
        temp_acc = 20'(t16 * 10);
        seen[FLAG_TEMP] = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic absorb_byte(input in_t item);
    logic [7:0] b;
    status_e    st;
    out_t       r;
    b = item.data_byte;
    case (phase)
      PH_HEADER: begin
        if (fr_count == 3'd0) begin
          uuid_lo = b;
        end else if (fr_count == 3'd1) begin
          if ({b, uuid_lo} != SERVICE_UUID) hdr_err = ST_UUID;
        end else begin
          if (hdr_err == ST_OK) begin
            if (b[0]) hdr_err = ST_ENCRYPTED;
            else if (b[7:5] != HDR_VERSION) hdr_err = ST_VERSION;
          end
          phase = (hdr_err != ST_OK) ? PH_STOP : PH_ID;
        end
      end
      PH_ID: begin
        obj_id = b;
        case (b)
          ID_PACKET, ID_BATTERY, ID_HUM_PCT: begin
            bytes_due = 2'd1;
            phase = PH_DATA;
          end
          ID_TEMP_CENTI, ID_HUM_CENTI, ID_TEMP_DECI: begin
            bytes_due = 2'd2;
            phase = PH_DATA;
          end
          default: phase = PH_STOP;
        endcase
      end
      PH_DATA: begin
        if (bytes_due == 2'd2) begin
          low_byte = b;
          bytes_due = 2'd1;
        end else begin
          store_object(b);
          bytes_due = 2'd0;
          phase = PH_ID;
        end
      end
      default: ;
    endcase
    if (fr_count != COUNT_MAX) fr_count = fr_count + 3'd1;
    bytes_taken++;
    if (item.last_byte) begin
      if (fr_count < MIN_LEN) st = ST_SHORT;
      else if (hdr_err != ST_OK) st = hdr_err;
      else if (seen[FLAG_TEMP] || seen[FLAG_HUM]) st = ST_OK;
      else st = ST_NO_READING;
      r = '0;
      r.status = st;
      if (st == ST_OK || st == ST_NO_READING) begin
        if (seen[FLAG_TEMP]) begin
          r.temperature_centi = temp_acc;
          r.temperature_valid = 1'b1;
        end
        if (seen[FLAG_HUM]) begin
          r.humidity_pct = hum_acc;
          r.humidity_valid = 1'b1;
        end
        if (seen[FLAG_BATT]) begin
          r.battery_level = batt_acc;
          r.battery_valid = 1'b1;
        end
      end
      expected_readings.push_back(r);
      frames_closed++;
      restart_frame();
    end
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      fail_count++;
    end
  endtask

  task automatic put(input logic [7:0] b);
    frame_buf.push_back(b);
  endtask

  task automatic put_header();
    put(SERVICE_UUID[7:0]);
    put(SERVICE_UUID[15:8]);
    put({HDR_VERSION, 5'b00000});
  endtask

  task automatic flush_frame();
    in_t item;
    while (frame_buf.size() != 0) begin
      item.data_byte = frame_buf.pop_front();
      item.last_byte = (frame_buf.size() == 0);
      pending_bytes.push_back(item);
    end
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_random_frame();
    int         kind;
    int         k;
    int         n_data;
    logic [7:0] id;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
    end else begin
      put(SERVICE_UUID[7:0]);
      put(SERVICE_UUID[15:8]);
      put({HDR_VERSION, 4'($urandom_range(0, 15)), 1'b0});
      if (kind == 1) begin
        k = $urandom_range(0, 2);
        frame_buf[k] = frame_buf[k] ^ 8'(1 << $urandom_range(0, 7));
      end
      repeat ($urandom_range(0, 5)) begin
        n_data = 2;
        case ($urandom_range(0, 12))
          0: id = ID_PACKET;
          1, 2: id = ID_BATTERY;
          3, 4: id = ID_TEMP_CENTI;
          5, 6: id = ID_HUM_CENTI;
          7, 8: id = ID_HUM_PCT;
          9, 10: id = ID_TEMP_DECI;
          default: id = 8'($urandom_range(0, 255));
        endcase
        if (id == ID_PACKET || id == ID_BATTERY || id == ID_HUM_PCT) n_data = 1;
        put(id);
        repeat (n_data) put(rand_data());
      end
      // chop the tail to leave a partial object
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          if (frame_buf.size() > 1) void'(frame_buf.pop_back());
        end
      end
    end
    flush_frame();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    if (!rst_ni) begin
      byte_valid <= 1'b0;
      byte_item  <= '0;
      gap_left   <= 0;
      quiet_tail <= 1'b0;
      restart_frame();
    end else begin
      if (byte_valid && !byte_stall) absorb_byte(byte_item);
      if (!byte_valid || !byte_stall) begin
        if (gap_left > 0) begin
          byte_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_bytes.size() == 0) begin
          byte_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
          byte_valid <= 1'b0;
          gap_left <= $urandom_range(0, 5);
        end else begin
          byte_item <= pending_bytes.pop_front();
          byte_valid <= 1'b1;
        end
      end
      quiet_tail <= (pending_bytes.size() < TAIL_BYTES);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    out_t head;
    if (!rst_ni) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_readings.size() == 0) begin
          $display("%0t: result with no frame pending, got status %0d", $time,
                   int'(result_item.status));
          fail_count++;
        end else begin
          head = expected_readings.pop_front();
          case (head.status)
            ST_OK: ok_count++;
            ST_NO_READING: none_count++;
            default: reject_count++;
          endcase
          check_field("status", int'(head.status), int'(result_item.status));
          check_field("temperature_centi", int'(head.temperature_centi),
                      int'(result_item.temperature_centi));
          check_field("temperature_valid", int'(head.temperature_valid),
                      int'(result_item.temperature_valid));
          check_field("humidity_pct", int'(head.humidity_pct),
                      int'(result_item.humidity_pct));
          check_field("humidity_valid", int'(head.humidity_valid),
                      int'(result_item.humidity_valid));
          check_field("battery_level", int'(head.battery_level),
                      int'(result_item.battery_level));
          check_field("battery_valid", int'(head.battery_valid),
                      int'(result_item.battery_valid));
        end
      end
      // hold off once for a long stretch so the input side backs up
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!held_once && results_seen == 30) begin
        held_once <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        stall_left <= $urandom_range(0, 5);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** bthome_v2_service_data_parser: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    // single short byte
    put(8'hFF);
    flush_frame();
    // extreme centi temperature and full battery
    put_header();
    put(ID_TEMP_CENTI); put(8'h00); put(8'h80);
    put(ID_BATTERY); put(8'hFF);
    flush_frame();
    // largest deci temperature and 16-bit humidity
    put_header();
    put(ID_TEMP_DECI); put(8'hFF); put(8'h7F);
    put(ID_HUM_CENTI); put(8'hFF); put(8'hFF);
    flush_frame();
    // smallest deci temperature, byte humidity, packet id
    put_header();
    put(ID_TEMP_DECI); put(8'h00); put(8'h80);
    put(ID_HUM_PCT); put(8'hFF);
    put(ID_PACKET); put(8'h00);
    flush_frame();
    // battery alone
    put_header();
    put(ID_PACKET); put(8'hAA);
    put(ID_BATTERY); put(8'h00);
    flush_frame();
    // nothing readable
    put_header();
    put(ID_PACKET); put(8'h01);
    put(ID_PACKET); put(8'h02);
    flush_frame();
    // bad uuid on a short frame
    put(8'hD2); put(8'hFD); put(8'h41);
    flush_frame();
    // bad uuid ranks above encryption
    put(8'hD3); put(8'hFC); put(8'h41); put(ID_TEMP_CENTI); put(8'h10); put(8'h00);
    flush_frame();
    // encryption ranks above version
    put(8'hD2); put(8'hFC); put(8'h61); put(ID_TEMP_CENTI); put(8'h10); put(8'h00);
    flush_frame();
    // wrong version
    put(8'hD2); put(8'hFC); put(8'h60); put(ID_TEMP_CENTI); put(8'h10); put(8'h00);
    flush_frame();
    // unknown id ends the walk
    put_header();
    put(ID_HUM_PCT); put(8'h32);
    put(8'h10);
    put(ID_TEMP_CENTI); put(8'h10); put(8'h00);
    flush_frame();
    // object cut short at the end
    put_header();
    put(ID_TEMP_CENTI); put(8'h34); put(8'h12);
    put(ID_HUM_CENTI); put(8'h10);
    flush_frame();
    // bare id at the end
    put_header();
    put(ID_BATTERY); put(8'h50);
    put(ID_TEMP_DECI);
    flush_frame();
    // later objects overwrite earlier ones
    put_header();
    put(ID_TEMP_CENTI); put(8'h01); put(8'h00);
    put(ID_TEMP_DECI); put(8'h01); put(8'h00);
    put(ID_HUM_PCT); put(8'h10);
    put(ID_HUM_CENTI); put(8'h10); put(8'h27);
    flush_frame();
    // a value just below a multiple of 100 in the 16-bit humidity
    put_header();
    put(ID_HUM_CENTI); put(8'hDB); put(8'hFF);
    flush_frame();

    while (pending_bytes.size() < STIM_BYTES) add_random_frame();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || byte_valid) @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (expected_readings.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_readings.size());
      fail_count++;
    end
    $display("Sent %0d bytes, %0d frames, %0d results (%0d ok, %0d empty, %0d rejected).",
             bytes_taken, frames_closed, results_seen, ok_count, none_count, reject_count);
    $display("Included header faults, unknown and cut objects, and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("** bthome_v2_service_data_parser: PASSED **");
    end else begin
      $display("** bthome_v2_service_data_parser: FAILED **");
    end
    $finish;
  end

endmodule
